// File: design/v3a_pkg.sv
// Shared types, constants and saturation helper for the vector3 ALU.
package v3a_pkg;

  localparam int unsigned DW         = 32;  // component width
  localparam int unsigned PW         = 64;  // product / sum-of-squares width
  localparam int unsigned RW         = 33;  // root and divisor magnitude width
  localparam int unsigned QW         = 48;  // quotient width (dividend << 16)
  localparam int unsigned FRAC       = 16;  // fraction bits
  localparam int unsigned SQ_STAGES  = 32;  // one root bit per stage
  localparam int unsigned DIV_STAGES = QW;  // one quotient bit per stage
  localparam int unsigned NPROD      = 6;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_SCALE  = 4'd4,
    CMD_DIVS   = 4'd5,
    CMD_DOT    = 4'd6,
    CMD_CROSS  = 4'd7,
    CMD_MAG    = 4'd8,
    CMD_SQRMAG = 4'd9,
    CMD_NORM   = 4'd10,
    CMD_EQUAL  = 4'd11
  } cmd_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [DW-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [DW-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]            cmd;
    logic [2:0][DW-1:0]    a;
    logic [2:0][DW-1:0]    b;
    logic [DW-1:0]         f;
  } req_t;

  // item traveling down the pipe
  typedef struct packed {
    logic [3:0]            cmd;
    logic [2:0][DW-1:0]    a;
    logic [2:0][RW-1:0]    dmag;
    logic [2:0]            dneg;
    logic [2:0][DW-1:0]    r;
    logic [DW-1:0]         sc;
    logic                  eq;
    logic                  sat;
  } item_t;

  typedef struct packed {
    logic [2:0][DW-1:0]    r;
    logic [DW-1:0]         sc;
    logic                  eq;
    logic [1:0]            status;
  } res_t;

  typedef struct packed {
    logic [DW-1:0]         val;
    logic                  sat;
  } clamp_t;

  function automatic clamp_t clamp66(input logic signed [65:0] v);
    clamp_t c;
    if (v > 66'sd2147483647) begin
      c.val = Q_MAX;
      c.sat = 1'b1;
    end else if (v < -66'sd2147483648) begin
      c.val = Q_MIN;
      c.sat = 1'b1;
    end else begin
      c.val = v[DW-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

// File: design/v3a_in_if.sv
// Request channel: command and operand vectors.
interface v3a_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        command;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] factor;

  modport source (output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                  input ready);
  modport sink (input valid, command, a_x, a_y, a_z, b_x, b_y, b_z, factor,
                output ready);
endinterface

// File: design/v3a_out_if.sv
// Result channel: vector, scalar, equality and status.
interface v3a_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic signed [31:0] res_scalar;
  logic              is_equal;
  logic [1:0]        status;

  modport source (output valid, res_x, res_y, res_z, res_scalar, is_equal, status,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, res_scalar, is_equal, status,
                output ready);
endinterface

// File: design/v3a_front.sv
// Front end: input register, six multipliers, sums, shifts and saturation.
module v3a_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  v3a_pkg::req_t            data_i,
  output logic                     valid_o,
  output v3a_pkg::item_t           item_o,
  output logic [v3a_pkg::PW-1:0]   ssq_o
);

  logic                   s1_v_q;
  v3a_pkg::req_t          s1_q;
  logic                   s2_v_q;
  v3a_pkg::item_t         s2_item_q;
  v3a_pkg::item_t         s2_item_d;
  logic signed [v3a_pkg::PW-1:0] prod_q [v3a_pkg::NPROD];
  logic signed [v3a_pkg::PW-1:0] prod_d [v3a_pkg::NPROD];
  logic signed [v3a_pkg::DW-1:0] ma [v3a_pkg::NPROD];
  logic signed [v3a_pkg::DW-1:0] mb [v3a_pkg::NPROD];
  logic                   s3_v_q;
  v3a_pkg::item_t         s3_item_q;
  v3a_pkg::item_t         s3_item_d;
  logic [v3a_pkg::PW-1:0] ssq_q;
  logic [v3a_pkg::PW-1:0] ssq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // operand select for the shared multipliers
  always_comb begin
    for (int k = 0; k < v3a_pkg::NPROD; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (s1_q.cmd) inside
      v3a_pkg::CMD_MUL, v3a_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = $signed(s1_q.a[i]);
          mb[2*i] = $signed(s1_q.b[i]);
        end
      end
      v3a_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = $signed(s1_q.a[i]);
          mb[2*i] = $signed(s1_q.f);
        end
      end
      v3a_pkg::CMD_MAG, v3a_pkg::CMD_SQRMAG, v3a_pkg::CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = $signed(s1_q.a[i]);
          mb[2*i] = $signed(s1_q.a[i]);
        end
      end
      v3a_pkg::CMD_CROSS: begin
        ma[0] = $signed(s1_q.a[1]); mb[0] = $signed(s1_q.b[2]);
        ma[1] = $signed(s1_q.a[2]); mb[1] = $signed(s1_q.b[1]);
        ma[2] = $signed(s1_q.a[2]); mb[2] = $signed(s1_q.b[0]);
        ma[3] = $signed(s1_q.a[0]); mb[3] = $signed(s1_q.b[2]);
        ma[4] = $signed(s1_q.a[0]); mb[4] = $signed(s1_q.b[1]);
        ma[5] = $signed(s1_q.a[1]); mb[5] = $signed(s1_q.b[0]);
      end
      default: ;
    endcase
    for (int k = 0; k < v3a_pkg::NPROD; k++) begin
      prod_d[k] = ma[k] * mb[k];
    end
  end

  // add/sub, equality and divisor magnitudes
  always_comb begin
    v3a_pkg::clamp_t        c;
    logic [v3a_pkg::DW-1:0] src;
    c = '0;
    src = '0;
    s2_item_d      = '0;
    s2_item_d.cmd  = s1_q.cmd;
    s2_item_d.a    = s1_q.a;
    for (int i = 0; i < 3; i++) begin
      src = (s1_q.cmd == v3a_pkg::CMD_DIVS) ? s1_q.f : s1_q.b[i];
      s2_item_d.dneg[i] = src[v3a_pkg::DW-1];
      s2_item_d.dmag[i] = src[v3a_pkg::DW-1] ? (~{src[v3a_pkg::DW-1], src} + 33'd1)
                                             : {1'b0, src};
      case (s1_q.cmd)
        v3a_pkg::CMD_ADD: begin
          c = v3a_pkg::clamp66(66'($signed(s1_q.a[i])) + 66'($signed(s1_q.b[i])));
          s2_item_d.r[i] = c.val;
          s2_item_d.sat  = s2_item_d.sat | c.sat;
        end
        v3a_pkg::CMD_SUB: begin
          c = v3a_pkg::clamp66(66'($signed(s1_q.a[i])) - 66'($signed(s1_q.b[i])));
          s2_item_d.r[i] = c.val;
          s2_item_d.sat  = s2_item_d.sat | c.sat;
        end
        default: ;
      endcase
    end
    if (s1_q.cmd == v3a_pkg::CMD_EQUAL) begin
      s2_item_d.eq = (s1_q.a == s1_q.b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q      <= data_i;
      s2_item_q <= s2_item_d;
      for (int k = 0; k < v3a_pkg::NPROD; k++) begin
        prod_q[k] <= prod_d[k];
      end
      s3_item_q <= s3_item_d;
      ssq_q     <= ssq_d;
    end
  end

  // product sums, Q32.32 -> Q16.16 with floor, saturate
  always_comb begin
    v3a_pkg::clamp_t   c;
    logic signed [65:0] s;
    logic signed [65:0] dot;
    c   = '0;
    s   = '0;
    s3_item_d = s2_item_q;
    ssq_d = prod_q[0] + prod_q[2] + prod_q[4];
    dot = 66'(prod_q[0]) + 66'(prod_q[2]) + 66'(prod_q[4]);
    case (s2_item_q.cmd) inside
      v3a_pkg::CMD_MUL, v3a_pkg::CMD_SCALE, v3a_pkg::CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          s = 66'(prod_q[2*i]) - 66'(prod_q[2*i+1]);
          c = v3a_pkg::clamp66(s >>> v3a_pkg::FRAC);
          s3_item_d.r[i] = c.val;
          s3_item_d.sat  = s3_item_d.sat | c.sat;
        end
      end
      v3a_pkg::CMD_DOT: begin
        c = v3a_pkg::clamp66(dot >>> v3a_pkg::FRAC);
        s3_item_d.sc  = c.val;
        s3_item_d.sat = c.sat;
      end
      v3a_pkg::CMD_SQRMAG: begin
        c = v3a_pkg::clamp66($signed({2'b00, ssq_d} >> v3a_pkg::FRAC));
        s3_item_d.sc  = c.val;
        s3_item_d.sat = c.sat;
      end
      default: ;
    endcase
  end

  assign valid_o = s3_v_q;
  assign item_o  = s3_item_q;
  assign ssq_o   = ssq_q;

endmodule

// File: design/v3a_sqrt.sv
// Pipelined floor square root of the sum of squares, one root bit per stage.
module v3a_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  v3a_pkg::item_t           item_i,
  input  logic [v3a_pkg::PW-1:0]   ssq_i,
  output logic                     valid_o,
  output v3a_pkg::item_t           item_o,
  output logic [v3a_pkg::RW-1:0]   root_o
);

  localparam int unsigned LAST = v3a_pkg::SQ_STAGES - 1;

  logic                   v_q    [v3a_pkg::SQ_STAGES];
  v3a_pkg::item_t         item_q [v3a_pkg::SQ_STAGES];
  logic [v3a_pkg::PW-1:0] rem_q  [v3a_pkg::SQ_STAGES];
  logic [v3a_pkg::PW-1:0] res_q  [v3a_pkg::SQ_STAGES];

  for (genvar k = 0; k < v3a_pkg::SQ_STAGES; k++) begin : g_stg
    localparam logic [v3a_pkg::PW-1:0] STEP_BIT =
      v3a_pkg::PW'(1) << (v3a_pkg::PW - 2 - 2 * k);

    logic                   v_in;
    v3a_pkg::item_t         it_in;
    logic [v3a_pkg::PW-1:0] rem_in;
    logic [v3a_pkg::PW-1:0] res_in;
    logic [v3a_pkg::PW-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign it_in  = item_i;
      assign rem_in = ssq_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign it_in  = item_q[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + STEP_BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= it_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + STEP_BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[LAST];
  assign item_o  = item_q[LAST];
  assign root_o  = res_q[LAST][v3a_pkg::RW-1:0];

endmodule

// File: design/v3a_div.sv
// Divider lanes: operand setup, then one restoring quotient bit per stage.
module v3a_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  v3a_pkg::item_t                item_i,
  input  logic [v3a_pkg::RW-1:0]        root_i,
  output logic                          valid_o,
  output v3a_pkg::item_t                item_o,
  output logic [2:0][v3a_pkg::QW-1:0]   quo_o
);

  localparam int unsigned RMW  = v3a_pkg::RW + 1;
  localparam int unsigned LAST = v3a_pkg::DIV_STAGES - 1;

  logic                          pv_q;
  v3a_pkg::item_t                pitem_q;
  v3a_pkg::item_t                pitem_d;
  logic [2:0][v3a_pkg::QW-1:0]   pnum_q;
  logic [2:0][v3a_pkg::QW-1:0]   pnum_d;

  logic                          v_q    [v3a_pkg::DIV_STAGES];
  v3a_pkg::item_t                item_q [v3a_pkg::DIV_STAGES];
  logic [2:0][v3a_pkg::QW-1:0]   quo_q  [v3a_pkg::DIV_STAGES];
  logic [2:0][RMW-1:0]           rem_q  [v3a_pkg::DIV_STAGES];

  // setup: normalize divides by the root, magnitude result leaves here
  always_comb begin
    v3a_pkg::clamp_t        c;
    logic [v3a_pkg::DW-1:0] nmag;
    c    = '0;
    nmag = '0;
    pitem_d = item_i;
    if (item_i.cmd == v3a_pkg::CMD_NORM) begin
      for (int i = 0; i < 3; i++) begin
        pitem_d.dmag[i] = root_i;
        pitem_d.dneg[i] = 1'b0;
      end
    end
    if (item_i.cmd == v3a_pkg::CMD_MAG) begin
      c = v3a_pkg::clamp66($signed({33'd0, root_i}));
      pitem_d.sc  = c.val;
      pitem_d.sat = c.sat;
    end
    for (int i = 0; i < 3; i++) begin
      nmag = item_i.a[i][v3a_pkg::DW-1] ? (~item_i.a[i] + 32'd1) : item_i.a[i];
      pnum_d[i] = {nmag, {v3a_pkg::FRAC{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pitem_q <= pitem_d;
      pnum_q  <= pnum_d;
    end
  end

  for (genvar j = 0; j < v3a_pkg::DIV_STAGES; j++) begin : g_stg
    logic                        v_in;
    v3a_pkg::item_t              it_in;
    logic [2:0][v3a_pkg::QW-1:0] quo_in;
    logic [2:0][RMW-1:0]         rem_in;
    logic [2:0][v3a_pkg::QW-1:0] quo_n;
    logic [2:0][RMW-1:0]         rem_n;

    if (j == 0) begin : g_first
      assign v_in   = pv_q;
      assign it_in  = pitem_q;
      assign quo_in = pnum_q;
      assign rem_in = '0;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign it_in  = item_q[j-1];
      assign quo_in = quo_q[j-1];
      assign rem_in = rem_q[j-1];
    end

    // dividend bits shift out of the top while quotient bits shift in
    always_comb begin
      logic [RMW-1:0] sh;
      sh = '0;
      for (int i = 0; i < 3; i++) begin
        sh = {rem_in[i][RMW-2:0], quo_in[i][v3a_pkg::QW-1]};
        if (sh >= {1'b0, it_in.dmag[i]}) begin
          rem_n[i] = sh - {1'b0, it_in.dmag[i]};
          quo_n[i] = {quo_in[i][v3a_pkg::QW-2:0], 1'b1};
        end else begin
          rem_n[i] = sh;
          quo_n[i] = {quo_in[i][v3a_pkg::QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[j] <= it_in;
        quo_q[j]  <= quo_n;
        rem_q[j]  <= rem_n;
      end
    end
  end

  assign valid_o = v_q[LAST];
  assign item_o  = item_q[LAST];
  assign quo_o   = quo_q[LAST];

endmodule

// File: design/vector3_alu_unit.sv
// Vector3 ALU top level: pipeline, quotient formatting, output register and skid.
// Usage:
//   req_i carries one request per valid/ready handshake: a command, vectors a
//   and b and a scalar factor, all Q16.16. res_o returns exactly one result per
//   request, in request order: a vector, a scalar, an equality bit and status.
//   Every command takes the same path, through the longest chain that normalize
//   needs: the 32-stage square root followed by the 48-stage divider.
//   Throughput is one request per cycle while the skid register is empty.
//   When res_o stalls, a result waits in the output register and the next one
//   lands in a skid register; only with the skid full does the whole pipe hold
//   (req_i.ready low) until res_o takes a result. Nothing is lost or repeated.
//   Reset clears all valid bits; the pipe starts empty and accepts at once.
module vector3_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  v3a_in_if.sink      req_i,
  v3a_out_if.source   res_o
);

  logic                          en;
  v3a_pkg::req_t                 din;

  logic                          fr_v;
  v3a_pkg::item_t                fr_item;
  logic [v3a_pkg::PW-1:0]        fr_ssq;
  logic                          sq_v;
  v3a_pkg::item_t                sq_item;
  logic [v3a_pkg::RW-1:0]        sq_root;
  logic                          dv_v;
  v3a_pkg::item_t                dv_item;
  logic [2:0][v3a_pkg::QW-1:0]   dv_quo;

  v3a_pkg::res_t                 fmt_d;
  v3a_pkg::res_t                 fmt_q;
  logic                          fmt_v_q;
  v3a_pkg::res_t                 out_q;
  logic                          out_v_q;
  v3a_pkg::res_t                 skid_q;
  logic                          skid_v_q;
  logic                          push;
  logic                          out_free;

  assign en          = !skid_v_q;
  assign req_i.ready = en;

  assign din.cmd  = req_i.command;
  assign din.a[0] = req_i.a_x;
  assign din.a[1] = req_i.a_y;
  assign din.a[2] = req_i.a_z;
  assign din.b[0] = req_i.b_x;
  assign din.b[1] = req_i.b_y;
  assign din.b[2] = req_i.b_z;
  assign din.f    = req_i.factor;

  v3a_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .data_i  (din),
    .valid_o (fr_v),
    .item_o  (fr_item),
    .ssq_o   (fr_ssq)
  );

  v3a_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .item_i  (fr_item),
    .ssq_i   (fr_ssq),
    .valid_o (sq_v),
    .item_o  (sq_item),
    .root_o  (sq_root)
  );

  v3a_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .item_i  (sq_item),
    .root_i  (sq_root),
    .valid_o (dv_v),
    .item_o  (dv_item),
    .quo_o   (dv_quo)
  );

  // sign, divide-by-zero and saturation for quotient commands
  always_comb begin
    v3a_pkg::clamp_t    c;
    logic signed [49:0] sv;
    logic               dz;
    logic               sat;
    logic               isdiv;
    c     = '0;
    sv    = '0;
    dz    = 1'b0;
    sat   = dv_item.sat;
    isdiv = 1'b0;
    fmt_d.r  = dv_item.r;
    fmt_d.sc = dv_item.sc;
    fmt_d.eq = dv_item.eq;
    case (dv_item.cmd) inside
      v3a_pkg::CMD_DIV, v3a_pkg::CMD_DIVS, v3a_pkg::CMD_NORM: isdiv = 1'b1;
      default: isdiv = 1'b0;
    endcase
    if (isdiv) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_item.dmag[i] == '0) begin
          // zero vector normalizes to zero without a flag
          if (dv_item.cmd == v3a_pkg::CMD_NORM) begin
            fmt_d.r[i] = '0;
          end else begin
            dz = 1'b1;
            if (dv_item.a[i] == '0) begin
              fmt_d.r[i] = '0;
            end else if (dv_item.a[i][v3a_pkg::DW-1]) begin
              fmt_d.r[i] = v3a_pkg::Q_MIN;
            end else begin
              fmt_d.r[i] = v3a_pkg::Q_MAX;
            end
          end
        end else begin
          sv = $signed({2'b00, dv_quo[i]});
          if (dv_item.a[i][v3a_pkg::DW-1] ^ dv_item.dneg[i]) begin
            sv = -sv;
          end
          c = v3a_pkg::clamp66(66'(sv));
          fmt_d.r[i] = c.val;
          sat = sat | c.sat;
        end
      end
    end
    fmt_d.status = dz ? v3a_pkg::ST_DZ : (sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_v_q <= 1'b0;
    end else if (en) begin
      fmt_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fmt_q <= fmt_d;
    end
  end

  assign push     = en && fmt_v_q;
  assign out_free = !out_v_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : fmt_q;
    end else if (push) begin
      skid_q <= fmt_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.res_x      = out_q.r[0];
  assign res_o.res_y      = out_q.r[1];
  assign res_o.res_z      = out_q.r[2];
  assign res_o.res_scalar = out_q.sc;
  assign res_o.is_equal   = out_q.eq;
  assign res_o.status     = out_q.status;

endmodule
